// ===== design/lkct_pkg.sv =====
// shared types and constants for the lru keyed cache table
// no dependencies; used by the interfaces and all design modules
package lkct_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned AGE_BITS   = 48;
  localparam int unsigned IDX_W      = $clog2(ENTRIES);
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned HANDLE_W   = 32;
  localparam int unsigned KIND_W     = 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NOP    = 2'd3
  } kind_e;

  // controller to datapath
  typedef struct packed {
    logic start;   // capture request, restart scan
    logic scan;    // read the slot at the scan index
    logic commit;  // apply the request and load the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } dp_status_t;

endpackage

// ===== design/lkct_if.sv =====
// request and response channel interfaces for the lru keyed cache table
// depends on lkct_pkg
interface lkct_req_if;
  logic                           valid;
  logic                           ready;
  logic [lkct_pkg::KIND_W-1:0]    kind;
  logic [lkct_pkg::KEY_W-1:0]     key;
  logic [lkct_pkg::HANDLE_W-1:0]  handle;
  logic                           loaded;

  modport source (output valid, kind, key, handle, loaded, input ready);
  modport sink   (input valid, kind, key, handle, loaded, output ready);
endinterface

interface lkct_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [lkct_pkg::HANDLE_W-1:0]  hit_handle;
  logic                           start_load;
  logic                           evicted;
  logic [lkct_pkg::KEY_W-1:0]     evicted_key;

  modport source (output valid, hit, hit_handle, start_load, evicted, evicted_key,
                  input ready);
  modport sink   (input valid, hit, hit_handle, start_load, evicted, evicted_key,
                  output ready);
endinterface

// ===== design/lkct_ctrl.sv =====
// controller state machine: sequences capture, slot scan and commit
// depends on lkct_pkg
module lkct_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  lkct_pkg::dp_status_t status_i,
  output lkct_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      // last read data lands in the accumulators
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/lkct_datapath.sv =====
// datapath: slot memories, valid bits, age counter, scan accumulators, result register
// depends on lkct_pkg
module lkct_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lkct_pkg::ctrl_cmd_t                cmd_i,
  output lkct_pkg::dp_status_t               status_o,
  input  logic [lkct_pkg::KIND_W-1:0]        kind_i,
  input  logic [lkct_pkg::KEY_W-1:0]         key_i,
  input  logic [lkct_pkg::HANDLE_W-1:0]      handle_i,
  input  logic                               loaded_i,
  output logic                               hit_o,
  output logic [lkct_pkg::HANDLE_W-1:0]      hit_handle_o,
  output logic                               start_load_o,
  output logic                               evicted_o,
  output logic [lkct_pkg::KEY_W-1:0]         evicted_key_o
);

  localparam int unsigned IW = lkct_pkg::IDX_W;
  localparam int unsigned AW = lkct_pkg::AGE_BITS;
  localparam int unsigned KW = lkct_pkg::KEY_W;
  localparam int unsigned HW = lkct_pkg::HANDLE_W;
  localparam int unsigned N  = lkct_pkg::ENTRIES;

  // slot storage
  logic [KW-1:0] key_mem [N];
  logic [AW-1:0] age_mem [N];
  logic          rdy_mem [N];
  logic [HW-1:0] hdl_mem [N];
  logic [N-1:0]  valid_q, valid_d;
  logic [AW-1:0] age_cnt_q, age_cnt_d;

  // captured request
  lkct_pkg::kind_e req_kind_q;
  logic [KW-1:0]   req_key_q;
  logic [HW-1:0]   req_hdl_q;
  logic            req_loaded_q;

  // scan pipeline
  logic [IW-1:0] cnt_q;
  logic          rd_vld_q;
  logic [IW-1:0] rd_idx_q;
  logic          rd_valid_q;
  logic [KW-1:0] rd_key_q;
  logic [AW-1:0] rd_age_q;
  logic          rd_rdy_q;
  logic [HW-1:0] rd_hdl_q;

  // accumulators
  logic          match_q;
  logic [IW-1:0] match_idx_q;
  logic          match_rdy_q;
  logic [HW-1:0] match_hdl_q;
  logic          free_q;
  logic [IW-1:0] free_idx_q;
  logic          vict_q;
  logic [IW-1:0] vict_idx_q;
  logic [AW-1:0] vict_age_q;
  logic [KW-1:0] vict_key_q;

  // commit decode
  logic          wr_full, wr_age;
  logic [IW-1:0] wr_idx;
  logic [AW-1:0] wr_age_val;
  logic          res_hit, res_load, res_evict;
  logic [HW-1:0] res_hdl;
  logic [KW-1:0] res_ekey;

  assign status_o.scan_last = (cnt_q == lkct_pkg::LAST_IDX);

  always_comb begin
    wr_full    = 1'b0;
    wr_age     = 1'b0;
    wr_idx     = match_idx_q;
    wr_age_val = age_cnt_q;
    age_cnt_d  = age_cnt_q;
    valid_d    = valid_q;
    res_hit    = 1'b0;
    res_load   = 1'b0;
    res_evict  = 1'b0;
    res_hdl    = '0;
    res_ekey   = '0;
    unique case (req_kind_q)
      lkct_pkg::KIND_LOOKUP: begin
        if (!match_q) begin
          res_load = 1'b1;
        end else begin
          age_cnt_d = age_cnt_q + AW'(1);
          if (match_rdy_q) begin
            wr_age     = 1'b1;
            wr_age_val = age_cnt_d;
            res_hit    = 1'b1;
            res_hdl    = match_hdl_q;
          end
        end
      end
      lkct_pkg::KIND_UPDATE: begin
        wr_full   = 1'b1;
        wr_age    = 1'b1;
        age_cnt_d = age_cnt_q + AW'(1);
        if (match_q) begin
          wr_idx = match_idx_q;
        end else if (free_q) begin
          wr_idx = free_idx_q;
        end else begin
          // table full: replace the oldest slot
          wr_idx    = vict_idx_q;
          res_evict = 1'b1;
          res_ekey  = vict_key_q;
        end
        valid_d[wr_idx] = 1'b1;
      end
      lkct_pkg::KIND_CLEAR: begin
        valid_d = '0;
      end
      lkct_pkg::KIND_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      age_cnt_q <= '0;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      match_q   <= 1'b0;
      free_q    <= 1'b0;
      vict_q    <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan;
      if (cmd_i.start) begin
        cnt_q   <= '0;
        match_q <= 1'b0;
        free_q  <= 1'b0;
        vict_q  <= 1'b0;
      end else begin
        if (cmd_i.scan) begin
          cnt_q <= cnt_q + IW'(1);
        end
        if (rd_vld_q) begin
          if (rd_valid_q && rd_key_q == req_key_q) begin
            match_q <= 1'b1;
          end
          if (!rd_valid_q) begin
            free_q <= 1'b1;
          end
          if (rd_valid_q) begin
            vict_q <= 1'b1;
          end
        end
      end
      if (cmd_i.commit) begin
        valid_q   <= valid_d;
        age_cnt_q <= age_cnt_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_kind_q   <= lkct_pkg::kind_e'(kind_i);
      req_key_q    <= key_i;
      req_hdl_q    <= handle_i;
      req_loaded_q <= loaded_i;
    end
    if (cmd_i.scan) begin
      rd_idx_q   <= cnt_q;
      rd_valid_q <= valid_q[cnt_q];
    end
    if (rd_vld_q && !cmd_i.start) begin
      // first valid slot holding the key
      if (rd_valid_q && rd_key_q == req_key_q && !match_q) begin
        match_idx_q <= rd_idx_q;
        match_rdy_q <= rd_rdy_q;
        match_hdl_q <= rd_hdl_q;
      end
      // lowest free slot
      if (!rd_valid_q && !free_q) begin
        free_idx_q <= rd_idx_q;
      end
      // smallest age, lowest index on ties
      if (rd_valid_q && (!vict_q || rd_age_q < vict_age_q)) begin
        vict_idx_q <= rd_idx_q;
        vict_age_q <= rd_age_q;
        vict_key_q <= rd_key_q;
      end
    end
    if (cmd_i.commit) begin
      hit_o         <= res_hit;
      hit_handle_o  <= res_hdl;
      start_load_o  <= res_load;
      evicted_o     <= res_evict;
      evicted_key_o <= res_ekey;
    end
  end

  // slot memories: one write port, one registered read port at the scan index
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_full) begin
      key_mem[wr_idx] <= req_key_q;
      rdy_mem[wr_idx] <= req_loaded_q;
      hdl_mem[wr_idx] <= req_hdl_q;
    end
    if (cmd_i.commit && wr_age) begin
      age_mem[wr_idx] <= wr_age_val;
    end
    if (cmd_i.scan) begin
      rd_key_q <= key_mem[cnt_q];
      rd_age_q <= age_mem[cnt_q];
      rd_rdy_q <= rdy_mem[cnt_q];
      rd_hdl_q <= hdl_mem[cnt_q];
    end
  end

endmodule

// ===== design/lru_keyed_cache_table.sv =====
// Keyed table of ENTRIES slots with age-stamp LRU replacement. Every request
// (lookup, update, clear, nop) gets a valid response after acceptance, once it has
// passed through a scan state that reads each slot over the single read port of the
// slot memory for the key, the first free slot and the oldest slot, a drain state
// for the last read to land, and a commit state that writes the slot and loads the
// response register. The next request is taken in the idle state after commit. A
// request is taken only when the previous one has committed; a finished response
// may wait in its register while the next request runs, and commit holds while it
// waits. Valid bits are cleared by the asynchronous reset, so there is no clearing
// pass after reset.
// depends on lkct_pkg, lkct_if, lkct_ctrl, lkct_datapath
module lru_keyed_cache_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  lkct_req_if.sink          req_i,
  lkct_rsp_if.source        rsp_o
);

  lkct_pkg::ctrl_cmd_t  cmd;
  lkct_pkg::dp_status_t status;

  lkct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lkct_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .kind_i        (req_i.kind),
    .key_i         (req_i.key),
    .handle_i      (req_i.handle),
    .loaded_i      (req_i.loaded),
    .hit_o         (rsp_o.hit),
    .hit_handle_o  (rsp_o.hit_handle),
    .start_load_o  (rsp_o.start_load),
    .evicted_o     (rsp_o.evicted),
    .evicted_key_o (rsp_o.evicted_key)
  );

endmodule
